// ===== rtl/core/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, constants and stage word types for the matrix-to-quaternion
// pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int SUM_W      = DATA_WIDTH + 3;       // trace / sqrt argument
  localparam int NUM_W      = DATA_WIDTH + 1;       // Shepperd numerators
  localparam int ARG_W      = DATA_WIDTH + 1;       // positive argument
  localparam int RAD_W      = 2 * ((ARG_W + FRAC_BITS + 1) / 2);
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int DIVS_W     = ROOT_W + 1;           // divisor 2r
  localparam int DVD_W      = NUM_W + FRAC_BITS;    // (|num| << F) + r
  // r >= 2^(F/2) when not degenerate, so the top bits never yield a quotient
  localparam int QLOG_MIN   = FRAC_BITS / 2 + 1;
  localparam int Q_W        = DVD_W - QLOG_MIN + 1;
  localparam int DIV_STAGES = Q_W;
  localparam int SQRT_STAGES = ROOT_W;

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_M00   = 2'd1;
  localparam logic [1:0] BR_M11   = 2'd2;
  localparam logic [1:0] BR_M22   = 2'd3;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       br;
    logic             degen;
    logic [RAD_W-1:0] rad;
    num_t             n0;
    num_t             n1;
    num_t             n2;
  } front_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        br;
    logic              degen;
    logic [ROOT_W-1:0] root;
    num_t              n0;
    num_t              n1;
    num_t              n2;
  } root_word_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        br;
    logic              degen;
    logic [ROOT_W-1:0] root;
    logic [2:0]        neg;
    logic [Q_W-1:0]    q0;
    logic [Q_W-1:0]    q1;
    logic [Q_W-1:0]    q2;
  } div_word_t;

endpackage

// ===== rtl/core/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Branch choice, square-root argument and numerators, one register stage.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m00, m01, m02,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m10, m11, m12,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m20, m21, m22,
  output rmq_pkg::front_t                     out_word
);
  localparam int SW = rmq_pkg::SUM_W;
  localparam int NW = rmq_pkg::NUM_W;

  rmq_pkg::front_t word_r, word_nxt;
  logic signed [SW-1:0] a00, a11, a22, t, arg;

  assign a00 = SW'(m00);
  assign a11 = SW'(m11);
  assign a22 = SW'(m22);
  assign t   = a00 + a11 + a22;

  always_comb begin
    word_nxt       = '0;
    word_nxt.valid = in_valid;
    if (t > 0) begin
      word_nxt.br = rmq_pkg::BR_TRACE;
      arg         = t + rmq_pkg::ONE;
      word_nxt.n0 = NW'(m21) - NW'(m12);
      word_nxt.n1 = NW'(m02) - NW'(m20);
      word_nxt.n2 = NW'(m10) - NW'(m01);
    end else if (m00 > m11 && m00 > m22) begin
      word_nxt.br = rmq_pkg::BR_M00;
      arg         = rmq_pkg::ONE + a00 - a11 - a22;
      word_nxt.n0 = NW'(m21) - NW'(m12);
      word_nxt.n1 = NW'(m01) + NW'(m10);
      word_nxt.n2 = NW'(m02) + NW'(m20);
    end else if (m11 > m22) begin
      word_nxt.br = rmq_pkg::BR_M11;
      arg         = rmq_pkg::ONE + a11 - a00 - a22;
      word_nxt.n0 = NW'(m02) - NW'(m20);
      word_nxt.n1 = NW'(m01) + NW'(m10);
      word_nxt.n2 = NW'(m12) + NW'(m21);
    end else begin
      word_nxt.br = rmq_pkg::BR_M22;
      arg         = rmq_pkg::ONE + a22 - a00 - a11;
      word_nxt.n0 = NW'(m10) - NW'(m01);
      word_nxt.n1 = NW'(m02) + NW'(m20);
      word_nxt.n2 = NW'(m12) + NW'(m21);
    end
    word_nxt.degen = (arg <= 0);
    if (arg > 0) begin
      word_nxt.rad = rmq_pkg::RAD_W'(arg[rmq_pkg::ARG_W-1:0]) << rmq_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end
  end

  assign out_word = word_r;
endmodule

// ===== rtl/core/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt
// Integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  rmq_pkg::front_t     in_word,
  output rmq_pkg::root_word_t out_word
);
  localparam int N  = rmq_pkg::SQRT_STAGES;
  localparam int RW = rmq_pkg::RAD_W;
  localparam int MW = rmq_pkg::REM_W;
  localparam int OW = rmq_pkg::ROOT_W;

  typedef struct packed {
    logic             valid;
    logic [1:0]       br;
    logic             degen;
    rmq_pkg::num_t    n0;
    rmq_pkg::num_t    n1;
    rmq_pkg::num_t    n2;
    logic [RW-1:0]    rad;
    logic [MW-1:0]    rem;
    logic [OW-1:0]    root;
  } sq_stage_t;

  sq_stage_t st [0:N];
  sq_stage_t head_w;

  always_comb begin
    head_w       = '0;
    head_w.valid = in_word.valid;
    head_w.br    = in_word.br;
    head_w.degen = in_word.degen;
    head_w.n0    = in_word.n0;
    head_w.n1    = in_word.n1;
    head_w.n2    = in_word.n2;
    head_w.rad   = in_word.rad;
  end

  assign st[0] = head_w;

  for (genvar k = 0; k < N; k++) begin : g_stage
    sq_stage_t s_r, s_nxt;
    logic [MW-1:0] rem_w, trial;
    always_comb begin
      s_nxt = st[k];
      rem_w = {st[k].rem[MW-3:0], st[k].rad[RW-1 -: 2]};
      trial = {st[k].root, 2'b01};
      s_nxt.rad = st[k].rad << 2;
      if (rem_w >= trial) begin
        s_nxt.rem  = rem_w - trial;
        s_nxt.root = {st[k].root[OW-2:0], 1'b1};
      end else begin
        s_nxt.rem  = rem_w;
        s_nxt.root = {st[k].root[OW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      s_r <= s_nxt;
      if (!rst_n) begin
        s_r.valid <= 1'b0;
      end
    end
    assign st[k+1] = s_r;
  end

  assign out_word.valid = st[N].valid;
  assign out_word.br    = st[N].br;
  assign out_word.degen = st[N].degen;
  assign out_word.root  = st[N].root;
  assign out_word.n0    = st[N].n0;
  assign out_word.n1    = st[N].n1;
  assign out_word.n2    = st[N].n2;
endmodule

// ===== rtl/core/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Three rounded divisions by 2r, restoring, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rmq_pkg::root_word_t in_word,
  output rmq_pkg::div_word_t  out_word
);
  localparam int N  = rmq_pkg::DIV_STAGES;
  localparam int QW = rmq_pkg::Q_W;
  localparam int DW = rmq_pkg::DVD_W;
  localparam int SW = rmq_pkg::DIVS_W;
  localparam int MW = SW + 1;
  localparam int HW = DW - QW;   // dividend bits preloaded into the remainder

  typedef struct packed {
    logic                   valid;
    logic [1:0]             br;
    logic                   degen;
    logic [rmq_pkg::ROOT_W-1:0] root;
    logic [2:0]             neg;
    logic [SW-1:0]          dvs;
    logic [2:0][MW-1:0]     rem;
    logic [2:0][QW-1:0]     q;     // low dividend bits shift out, quotient in
  } dv_stage_t;

  dv_stage_t st [0:N];
  dv_stage_t head_w;
  rmq_pkg::num_t n [3];
  logic [DW-1:0] dvd [3];

  assign n[0] = in_word.n0;
  assign n[1] = in_word.n1;
  assign n[2] = in_word.n2;

  always_comb begin
    head_w       = '0;
    head_w.valid = in_word.valid;
    head_w.br    = in_word.br;
    head_w.degen = in_word.degen;
    head_w.root  = in_word.root;
    head_w.dvs   = {in_word.root, 1'b0};
    for (int i = 0; i < 3; i++) begin
      head_w.neg[i] = n[i][rmq_pkg::NUM_W-1];
      dvd[i] = {(n[i][rmq_pkg::NUM_W-1] ? -n[i] : n[i]), {rmq_pkg::FRAC_BITS{1'b0}}}
             + DW'(in_word.root);
      head_w.rem[i] = MW'(dvd[i][DW-1 -: HW]);
      head_w.q[i]   = dvd[i][QW-1:0];
    end
  end

  assign st[0] = head_w;

  for (genvar k = 0; k < N; k++) begin : g_stage
    dv_stage_t s_r, s_nxt;
    logic [MW-1:0] rem_w [3];
    always_comb begin
      s_nxt = st[k];
      for (int i = 0; i < 3; i++) begin
        rem_w[i] = {st[k].rem[i][MW-2:0], st[k].q[i][QW-1]};
        if (rem_w[i] >= MW'(st[k].dvs)) begin
          s_nxt.rem[i] = rem_w[i] - MW'(st[k].dvs);
          s_nxt.q[i]   = {st[k].q[i][QW-2:0], 1'b1};
        end else begin
          s_nxt.rem[i] = rem_w[i];
          s_nxt.q[i]   = {st[k].q[i][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      s_r <= s_nxt;
      if (!rst_n) begin
        s_r.valid <= 1'b0;
      end
    end
    assign st[k+1] = s_r;
  end

  assign out_word.valid = st[N].valid;
  assign out_word.br    = st[N].br;
  assign out_word.degen = st[N].degen;
  assign out_word.root  = st[N].root;
  assign out_word.neg   = st[N].neg;
  assign out_word.q0    = st[N].q[0];
  assign out_word.q1    = st[N].q[1];
  assign out_word.q2    = st[N].q[2];
endmodule

// ===== rtl/core/rotation_matrix_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// 3x3 rotation matrix (Q2.14) to unit quaternion, Shepperd branch selection.
// ----------------------------------------------------------------------------
// A new matrix word may be issued on every clock: busy is never raised and
// the receiver cannot stall. Each word yields one result word on out_valid,
// passing in order through the front register, the bit-per-stage square
// root (16 root bits), the three parallel bit-per-stage dividers (24
// quotient bits) and the output register. Results hold one cycle.
// out_branch_used: 0 trace, 1/2/3 largest m00/m11/m22. out_degenerate flags
// a non-positive root argument; the quaternion is then zero.
module rotation_matrix_to_quaternion_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] in_m00, in_m01, in_m02,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] in_m10, in_m11, in_m12,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] in_m20, in_m21, in_m22,
  output logic                                  out_valid,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] out_quat_x,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] out_quat_y,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] out_quat_z,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] out_quat_w,
  output logic [1:0]                            out_branch_used,
  output logic                                  out_degenerate
);
  localparam int DW = rmq_pkg::DATA_WIDTH;
  localparam int QW = rmq_pkg::Q_W;
  localparam int OW = rmq_pkg::ROOT_W;

  typedef logic signed [DW-1:0] comp_t;

  rmq_pkg::front_t     fr_word;
  rmq_pkg::root_word_t sq_word;
  rmq_pkg::div_word_t  dv_word;

  // pipeline never holds off
  assign busy = 1'b0;

  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .m00      (in_m00), .m01 (in_m01), .m02 (in_m02),
    .m10      (in_m10), .m11 (in_m11), .m12 (in_m12),
    .m20      (in_m20), .m21 (in_m21), .m22 (in_m22),
    .out_word (fr_word)
  );

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (fr_word),
    .out_word (sq_word)
  );

  rmq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (sq_word),
    .out_word (dv_word)
  );

  // sign restore and saturation of an unsigned quotient magnitude
  function automatic comp_t sat_q(input logic [QW-1:0] mag, input logic neg);
    logic signed [QW:0] v;
    v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (v > $signed((QW+1)'({1'b0, {(DW-1){1'b1}}}))) begin
      return {1'b0, {(DW-1){1'b1}}};
    end else if (v < -$signed((QW+1)'({1'b0, {(DW-1){1'b1}}})) - 1) begin
      return {1'b1, {(DW-1){1'b0}}};
    end
    return v[DW-1:0];
  endfunction

  comp_t d0, d1, d2, big;
  logic [OW:0] big_w;
  comp_t qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  comp_t qx_r, qy_r, qz_r, qw_r;
  logic [1:0] br_r;
  logic degen_r, valid_r;

  assign d0    = sat_q(dv_word.q0, dv_word.neg[0]);
  assign d1    = sat_q(dv_word.q1, dv_word.neg[1]);
  assign d2    = sat_q(dv_word.q2, dv_word.neg[2]);
  assign big_w = ({1'b0, dv_word.root} + (OW+1)'(1)) >> 1;
  assign big   = DW'(big_w);

  always_comb begin
    qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
    if (!dv_word.degen) begin
      case (dv_word.br)
        rmq_pkg::BR_TRACE: begin
          qx_nxt = d0; qy_nxt = d1; qz_nxt = d2; qw_nxt = big;
        end
        rmq_pkg::BR_M00: begin
          qw_nxt = d0; qy_nxt = d1; qz_nxt = d2; qx_nxt = big;
        end
        rmq_pkg::BR_M11: begin
          qw_nxt = d0; qx_nxt = d1; qz_nxt = d2; qy_nxt = big;
        end
        default: begin
          qw_nxt = d0; qx_nxt = d1; qy_nxt = d2; qz_nxt = big;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    qz_r    <= qz_nxt;
    qw_r    <= qw_nxt;
    br_r    <= dv_word.br;
    degen_r <= dv_word.degen;
    valid_r <= dv_word.valid;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid       = valid_r;
  assign out_quat_x      = qx_r;
  assign out_quat_y      = qy_r;
  assign out_quat_z      = qz_r;
  assign out_quat_w      = qw_r;
  assign out_branch_used = br_r;
  assign out_degenerate  = degen_r;
endmodule
